// ----- src/tpm_pkg.sv -----
`default_nettype none

package tpm_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int LANES          = 4;
   localparam int WORD_BITS      = 64;
   localparam int CODES_PER_VOLT = 2048;
   localparam int GAIN_FULL      = 12;
   localparam int SUM_LIMIT      = 10 * CODES_PER_VOLT;
   localparam int OUT_BITS       = 16;
   localparam int GAIN_BITS      = 4;
   localparam int ADDR_BITS      = 4;
   localparam int DATA_BITS      = 32;

   // padded lane word, lane bits past the input word read as zero
   localparam int PAD_BITS = (LANES * SAMPLE_BITS > WORD_BITS) ? LANES * SAMPLE_BITS : WORD_BITS;

   // sample or the 1 V default, one bit wider so 2048 fits at narrow lanes
   localparam int S_W    = SAMPLE_BITS + 1;
   localparam int LEV_W  = SAMPLE_BITS + 1;
   localparam int TERM_W = S_W + GAIN_BITS + 1;
   localparam int ACC_W  = TERM_W + 2;
   localparam int MAG_W  = ACC_W;
   localparam int X_W    = MAG_W - 1;
   localparam int RECIP_K = X_W + 2;
   localparam logic [RECIP_K-1:0] RECIP =
      RECIP_K'(((64'd1 << RECIP_K) + 64'd2) / 64'd3);

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_ADD = 2'd1,
      MODE_INV = 2'd2
   } mode_type;

   typedef struct packed {
      logic next_high;
      logic fired;
   } schmitt_type;

   typedef struct packed {
      logic                     add_on;
      logic                     inv_on;
      logic signed [TERM_W-1:0] term;
   } chan_out_type;

   function automatic schmitt_type schmitt(input logic high, input logic signed [31:0] level);
      schmitt_type r;
      r.next_high = high;
      r.fired     = 1'b0;
      if (high) begin
         if (level <= 0) r.next_high = 1'b0;
      end else if (level >= CODES_PER_VOLT) begin
         r.next_high = 1'b1;
         r.fired     = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] lane(input logic [WORD_BITS-1:0] word,
                                                          input int idx);
      logic [PAD_BITS-1:0] padded;
      padded = PAD_BITS'(word);
      return padded[idx*SAMPLE_BITS +: SAMPLE_BITS];
   endfunction

endpackage

`default_nettype wire

// ----- src/tpm_if.sv -----
`default_nettype none

interface tpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [tpm_pkg::WORD_BITS-1:0] samples;
   logic [tpm_pkg::LANES-1:0]     plugged_mask;
   logic [tpm_pkg::WORD_BITS-1:0] add_levels;
   logic [tpm_pkg::WORD_BITS-1:0] invert_levels;
   logic [tpm_pkg::LANES-1:0]     add_buttons;
   logic [tpm_pkg::LANES-1:0]     invert_buttons;
   logic signed [15:0]            reset_level;

   modport source (output valid, samples, plugged_mask, add_levels, invert_levels,
                   add_buttons, invert_buttons, reset_level, input ready);
   modport sink   (input valid, samples, plugged_mask, add_levels, invert_levels,
                   add_buttons, invert_buttons, reset_level, output ready);
endinterface

interface tpm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tpm_pkg::OUT_BITS-1:0] sum_out;
   logic signed [tpm_pkg::OUT_BITS-1:0] inverted_sum_out;
   logic [tpm_pkg::LANES-1:0]           add_mask;
   logic [tpm_pkg::LANES-1:0]           invert_mask;

   modport source  (output valid, sum_out, inverted_sum_out, add_mask, invert_mask,
                    input ready);
   modport sink    (input valid, sum_out, inverted_sum_out, add_mask, invert_mask,
                    output ready);
   modport monitor (input valid, ready, sum_out, inverted_sum_out, add_mask, invert_mask);
endinterface

`default_nettype wire

// ----- src/four_channel_toggle_polarity_mixer_core.sv -----
// Stages: input register, sum register and output register, from an accepted request
//   transaction to a valid response. Throughput: one transaction per cycle unless the
//   response stalls; mode and trigger state turn over as stage 1 moves into stage 2.
// Reset (synchronous, active high): pipeline empty, all channels off, every Schmitt
//   trigger armed high, all gains 12.
`default_nettype none

module four_channel_toggle_polarity_mixer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tpm_req_if.sink                             req_chan,
   tpm_rsp_if.source                           rsp_chan,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tpm_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic [tpm_pkg::DATA_BITS-1:0]  pwdata,
   output logic      [tpm_pkg::DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   localparam int L  = tpm_pkg::LANES;

   // ---------------------------------------------------------------- config
   logic [tpm_pkg::GAIN_BITS-1:0] gain_ff [L];
   logic [1:0]                    csr_idx;

   assign csr_idx = paddr[3:2];
   assign pready  = 1'b1;
   assign prdata  = tpm_pkg::DATA_BITS'(gain_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) gain_ff[i] <= tpm_pkg::GAIN_BITS'(tpm_pkg::GAIN_FULL);
      end else if (psel && penable && pwrite && pready) begin
         gain_ff[csr_idx] <= pwdata[tpm_pkg::GAIN_BITS-1:0];
      end
   end

   // ---------------------------------------------------------- pipe control
   // Each stage loads when empty or when the stage after it moves.
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic fire1;

   assign rdy3  = !v3_ff || rsp_chan.ready;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign fire1 = v1_ff && rdy2;   // state advances here, one transaction per edge when stage 2 can load

   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_chan.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // ------------------------------------------------------- stage 1: input
   logic [tpm_pkg::WORD_BITS-1:0] samples_ff, add_lev_ff, inv_lev_ff;
   logic [L-1:0]                  plugged_ff, add_btn_ff, inv_btn_ff;
   logic signed [15:0]            rst_lev_ff;

   always_ff @(posedge clock) begin
      if (req_chan.valid && rdy1) begin
         samples_ff <= req_chan.samples;
         add_lev_ff <= req_chan.add_levels;
         inv_lev_ff <= req_chan.invert_levels;
         plugged_ff <= req_chan.plugged_mask;
         add_btn_ff <= req_chan.add_buttons;
         inv_btn_ff <= req_chan.invert_buttons;
         rst_lev_ff <= req_chan.reset_level;
      end
   end

   // ------------------------------------ stage 2: triggers, modes and sum
   // Reset trigger is evaluated with the rest but clears modes only for the next
   // transaction; this one still sums and reports the pre-clear modes.
   logic                  rst_high_ff;
   tpm_pkg::schmitt_type  rst_trig;
   tpm_pkg::chan_out_type ch_res [L];

   assign rst_trig = tpm_pkg::schmitt(rst_high_ff, 32'(rst_lev_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rst_high_ff <= 1'b1;
      end else if (fire1) begin
         rst_high_ff <= rst_trig.next_high;
      end
   end

   for (genvar i = 0; i < L; i++) begin : g_ch
      tpm_channel u_ch (
         .clock      (clock),
         .reset      (reset),
         .fire       (fire1),
         .clear      (rst_trig.fired),
         .add_level  (tpm_pkg::lane(add_lev_ff, i)),
         .add_button (add_btn_ff[i]),
         .inv_level  (tpm_pkg::lane(inv_lev_ff, i)),
         .inv_button (inv_btn_ff[i]),
         .sample     (tpm_pkg::lane(samples_ff, i)),
         .plugged    (plugged_ff[i]),
         .gain       (gain_ff[i]),
         .res        (ch_res[i])
      );
   end

   logic signed [tpm_pkg::ACC_W-1:0] acc_in, acc_ff;
   logic [L-1:0]                     amask_in, imask_in, amask_ff, imask_ff;

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < L; i++) begin
         acc_in      = acc_in + tpm_pkg::ACC_W'(ch_res[i].term);
         amask_in[i] = ch_res[i].add_on;
         imask_in[i] = ch_res[i].inv_on;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         acc_ff   <= acc_in;
         amask_ff <= amask_in;
         imask_ff <= imask_in;
      end
   end

   // ------------------------------ stage 3: divide by 12, round, saturate
   // |acc|/12 rounded half away from zero = floor(floor((|acc|+6)/4)/3);
   // the divide by 3 is a reciprocal multiply, exact over the whole range.
   logic                                   neg;
   logic [tpm_pkg::MAG_W-1:0]              mag;
   logic [tpm_pkg::MAG_W:0]                mag_r;
   logic [tpm_pkg::X_W-1:0]                x_val, q_val;
   logic [tpm_pkg::X_W+tpm_pkg::RECIP_K-1:0] q_prod;
   logic [tpm_pkg::OUT_BITS-1:0]           sat;
   logic signed [tpm_pkg::OUT_BITS-1:0]    sum_in;

   assign neg    = acc_ff[tpm_pkg::ACC_W-1];
   assign mag    = neg ? tpm_pkg::MAG_W'(-acc_ff) : tpm_pkg::MAG_W'(acc_ff);
   assign mag_r  = {1'b0, mag} + (tpm_pkg::MAG_W+1)'(tpm_pkg::GAIN_FULL / 2);
   assign x_val  = mag_r[tpm_pkg::MAG_W:2];
   assign q_prod = x_val * tpm_pkg::RECIP;
   assign q_val  = q_prod[tpm_pkg::X_W+tpm_pkg::RECIP_K-1:tpm_pkg::RECIP_K];
   assign sat    = (q_val > tpm_pkg::X_W'(tpm_pkg::SUM_LIMIT))
                 ? tpm_pkg::OUT_BITS'(tpm_pkg::SUM_LIMIT) : q_val[tpm_pkg::OUT_BITS-1:0];
   assign sum_in = neg ? -$signed(sat) : $signed(sat);

   logic signed [tpm_pkg::OUT_BITS-1:0] sum_ff, inv_sum_ff;
   logic [L-1:0]                        amask_o_ff, imask_o_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         sum_ff     <= sum_in;
         inv_sum_ff <= -sum_in;
         amask_o_ff <= amask_ff;
         imask_o_ff <= imask_ff;
      end
   end

   assign rsp_chan.valid            = v3_ff;
   assign rsp_chan.sum_out          = sum_ff;
   assign rsp_chan.inverted_sum_out = inv_sum_ff;
   assign rsp_chan.add_mask         = amask_o_ff;
   assign rsp_chan.invert_mask      = imask_o_ff;

endmodule

`default_nettype wire

// ----- src/tpm_channel.sv -----
`default_nettype none

module tpm_channel (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  fire,
   input  wire logic                                  clear,
   input  wire logic signed [tpm_pkg::SAMPLE_BITS-1:0] add_level,
   input  wire logic                                  add_button,
   input  wire logic signed [tpm_pkg::SAMPLE_BITS-1:0] inv_level,
   input  wire logic                                  inv_button,
   input  wire logic signed [tpm_pkg::SAMPLE_BITS-1:0] sample,
   input  wire logic                                  plugged,
   input  wire logic [tpm_pkg::GAIN_BITS-1:0]         gain,
   output tpm_pkg::chan_out_type                      res
);

   tpm_pkg::mode_type    mode_ff;
   logic                 add_high_ff;
   logic                 inv_high_ff;

   tpm_pkg::mode_type    mode_a;
   tpm_pkg::mode_type    mode_b;
   tpm_pkg::schmitt_type add_schmitt;
   tpm_pkg::schmitt_type inv_schmitt;
   logic signed [tpm_pkg::LEV_W-1:0]        add_sum;
   logic signed [tpm_pkg::LEV_W-1:0]        inv_sum;
   logic signed [tpm_pkg::S_W-1:0]          s_val;
   logic [tpm_pkg::GAIN_BITS-1:0]           g_val;
   logic signed [tpm_pkg::S_W+tpm_pkg::GAIN_BITS:0] prod;

   // button adds one volt to the trigger level
   assign add_sum = tpm_pkg::LEV_W'(add_level)
                  + (add_button ? tpm_pkg::LEV_W'(tpm_pkg::CODES_PER_VOLT) : '0);
   assign inv_sum = tpm_pkg::LEV_W'(inv_level)
                  + (inv_button ? tpm_pkg::LEV_W'(tpm_pkg::CODES_PER_VOLT) : '0);

   assign add_schmitt = tpm_pkg::schmitt(add_high_ff, 32'(add_sum));
   assign inv_schmitt = tpm_pkg::schmitt(inv_high_ff, 32'(inv_sum));

   always_comb begin
      mode_a = mode_ff;
      if (add_schmitt.fired) begin
         mode_a = (mode_ff == tpm_pkg::MODE_ADD) ? tpm_pkg::MODE_OFF : tpm_pkg::MODE_ADD;
      end
      mode_b = mode_a;
      if (inv_schmitt.fired) begin
         mode_b = (mode_a == tpm_pkg::MODE_INV) ? tpm_pkg::MODE_OFF : tpm_pkg::MODE_INV;
      end
   end

   // unplugged jack reads as 1 V; gain codes above twelve act as twelve
   assign s_val = plugged ? tpm_pkg::S_W'(sample) : tpm_pkg::S_W'(tpm_pkg::CODES_PER_VOLT);
   assign g_val = (gain > tpm_pkg::GAIN_BITS'(tpm_pkg::GAIN_FULL))
                ? tpm_pkg::GAIN_BITS'(tpm_pkg::GAIN_FULL) : gain;
   assign prod  = s_val * $signed({1'b0, g_val});

   always_comb begin
      res.add_on = 1'b0;
      res.inv_on = 1'b0;
      res.term   = '0;
      unique case (mode_b)
         tpm_pkg::MODE_ADD: begin
            res.add_on = 1'b1;
            res.term   = tpm_pkg::TERM_W'(prod);
         end
         tpm_pkg::MODE_INV: begin
            res.inv_on = 1'b1;
            res.term   = -tpm_pkg::TERM_W'(prod);
         end
         default: begin
            res.term = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= tpm_pkg::MODE_OFF;
         add_high_ff <= 1'b1;
         inv_high_ff <= 1'b1;
      end else if (fire) begin
         add_high_ff <= add_schmitt.next_high;
         inv_high_ff <= inv_schmitt.next_high;
         mode_ff     <= clear ? tpm_pkg::MODE_OFF : mode_b;
      end
   end

endmodule

`default_nettype wire

// ----- src/tpm_checker.sv -----
`default_nettype none

module tpm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic signed [tpm_pkg::OUT_BITS-1:0] rsp_sum,
   input wire logic signed [tpm_pkg::OUT_BITS-1:0] rsp_inv_sum,
   input wire logic [tpm_pkg::LANES-1:0]          rsp_add_mask,
   input wire logic [tpm_pkg::LANES-1:0]          rsp_invert_mask,
   input wire logic                               pready
);

   // a channel is never in add and invert mode at once
   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_add_mask & rsp_invert_mask) == '0)
      else $error("add and invert masks overlap");

   a_inverted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_inv_sum == -rsp_sum)
      else $error("inverted sum does not match sum");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_sum) <= tpm_pkg::SUM_LIMIT &&
                     int'(rsp_sum) >= -tpm_pkg::SUM_LIMIT))
      else $error("sum outside saturation limits");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind four_channel_toggle_polarity_mixer_core tpm_checker u_tpm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_sum         (rsp_chan.sum_out),
   .rsp_inv_sum     (rsp_chan.inverted_sum_out),
   .rsp_add_mask    (rsp_chan.add_mask),
   .rsp_invert_mask (rsp_chan.invert_mask),
   .pready          (pready)
);

`default_nettype wire
